// ===== design/fc_pkg.sv =====
// Shared types and codes for the Frenet-to-Cartesian converter.
package fc_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [1:0] ST_LOADED    = 2'd0;
    localparam logic [1:0] ST_CONVERTED = 2'd1;
    localparam logic [1:0] ST_CLAMPED   = 2'd2;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic               is_load;
        logic               wr_ok;
        logic [7:0]         index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        s;
        logic [30:0]        qs;
        logic signed [31:0] d;
    } t_item;

endpackage

// ===== design/fc_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
module fc_front #(
    parameter int MAX_WAYPOINTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_wp_index,
    input  logic signed [31:0] i_wp_x,
    input  logic signed [31:0] i_wp_y,
    input  logic [30:0]        i_wp_s,
    input  logic [30:0]        i_query_s,
    input  logic signed [31:0] i_query_d,
    output fc_pkg::t_item      o_item,
    output logic               o_item_valid,
    input  logic               i_item_pop
);
    import fc_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int PW = $clog2(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    t_item          r_q [QDEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [NW-1:0]  r_cnt;
    t_item          w_new;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_new.is_load = (i_opcode == OP_LOAD);
        w_new.wr_ok   = (CW'(i_wp_index) < CW'(MAX_WAYPOINTS));
        w_new.index   = i_wp_index;
        w_new.x       = i_wp_x;
        w_new.y       = i_wp_y;
        w_new.s       = i_wp_s;
        w_new.qs      = i_query_s;
        w_new.d       = i_query_d;
    end

    assign o_in_stall   = (r_cnt == NW'(QDEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

endmodule

// ===== design/fc_back.sv =====
// Back end: waypoint tables, segment search, unit vector and output register.
module fc_back #(
    parameter int MAX_WAYPOINTS = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fc_pkg::t_item           i_item,
    input  logic                    i_item_valid,
    output logic                    o_item_pop,
    input  logic [((($clog2(MAX_WAYPOINTS) + 1) > 9) ?
                   ($clog2(MAX_WAYPOINTS) + 1) : 9) - 1:0] i_count,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic [7:0]              o_segment_start,
    output logic [1:0]              o_status
);
    import fc_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RD0, S_CMP0, S_SRCH, S_SCMP, S_RDP, S_RDN, S_GOTN,
        S_NORM, S_SQ, S_SQRT, S_DIVI, S_DIV, S_UNIT, S_PROD, S_RND, S_FIN
    } t_state;

    logic [31:0] mem_x [MAX_WAYPOINTS];
    logic [31:0] mem_y [MAX_WAYPOINTS];
    logic [30:0] mem_s [MAX_WAYPOINTS];

    t_state             r_state;
    t_item              r_it;
    logic [CW-1:0]      r_n;
    logic [AW-1:0]      r_prev;
    logic               r_clamp;
    logic [31:0]        r_rdx;
    logic [31:0]        r_rdy;
    logic [30:0]        r_rds;
    logic signed [31:0] r_x0;
    logic signed [31:0] r_y0;
    logic signed [31:0] r_seg;
    logic [32:0]        r_ax;
    logic [32:0]        r_ay;
    logic               r_sx;
    logic               r_sy;
    logic [2:0]         r_step;
    logic signed [65:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_accy;
    logic [63:0]        r_v;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [4:0]         r_k;
    logic [31:0]        r_len;
    logic [31:0]        r_remx;
    logic [31:0]        r_remy;
    logic [31:0]        r_nqx;
    logic [31:0]        r_nqy;
    logic signed [31:0] r_ux;
    logic signed [31:0] r_uy;
    logic signed [34:0] r_rx;
    logic signed [34:0] r_ry;
    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic [7:0]         r_out_seg;
    logic [1:0]         r_out_status;

    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic               w_re;
    logic [AW-1:0]      w_ra;
    logic [CW-1:0]      w_idx_ext;
    logic [CW-1:0]      w_prev_ext;
    logic [CW-1:0]      w_prev1;
    logic [AW-1:0]      w_next;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_mult;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic [32:0]        w_m;
    logic [63:0]        w_sq_t;
    logic [61:0]        w_numx;
    logic [61:0]        w_numy;
    logic [32:0]        w_tx;
    logic [32:0]        w_ty;
    logic               w_gex;
    logic               w_gey;
    logic [31:0]        w_cx;
    logic [31:0]        w_cy;
    logic signed [63:0] w_sumx;
    logic signed [63:0] w_sumy;
    logic signed [33:0] w_qx;
    logic signed [33:0] w_qy;
    logic signed [31:0] w_satx;
    logic signed [31:0] w_saty;
    logic               w_out_free;

    assign w_idx_ext  = CW'(r_it.index);
    assign w_prev_ext = CW'(r_prev);
    assign w_prev1    = w_prev_ext + CW'(1);
    assign w_next     = (w_prev1 < r_n) ? w_prev1[AW-1:0] : '0;
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_we = (r_state == S_LOAD) && r_it.wr_ok;
        w_wa = w_idx_ext[AW-1:0];
        w_re = 1'b0;
        w_ra = '0;
        case (r_state)
            S_RD0: begin
                w_re = 1'b1;
            end
            S_SRCH: begin
                w_re = (w_prev1 < r_n);
                w_ra = w_prev1[AW-1:0];
            end
            S_RDP: begin
                w_re = 1'b1;
                w_ra = r_prev;
            end
            S_RDN: begin
                w_re = 1'b1;
                w_ra = w_next;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[w_wa] <= r_it.x;
            mem_y[w_wa] <= r_it.y;
            mem_s[w_wa] <= r_it.s;
        end
        if (w_re) begin
            r_rdx <= mem_x[w_ra];
            r_rdy <= mem_y[w_ra];
            r_rds <= mem_s[w_ra];
        end
    end

    // One shared multiplier serves the sum of squares and the four products.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_SQ) begin
            w_ma = r_step[0] ? $signed(r_ay) : $signed(r_ax);
            w_mb = w_ma;
        end else if (r_state == S_PROD) begin
            case (r_step)
                3'd0: begin
                    w_ma = {r_seg[31], r_seg};
                    w_mb = {r_ux[31], r_ux};
                end
                3'd1: begin
                    w_ma = {r_it.d[31], r_it.d};
                    w_mb = {r_uy[31], r_uy};
                end
                3'd2: begin
                    w_ma = {r_seg[31], r_seg};
                    w_mb = {r_uy[31], r_uy};
                end
                default: begin
                    w_ma = {r_it.d[31], r_it.d};
                    w_mb = {r_ux[31], r_ux};
                end
            endcase
        end
    end

    assign w_mult = w_ma * w_mb;

    assign w_dx   = $signed({r_rdx[31], r_rdx}) - $signed({r_x0[31], r_x0});
    assign w_dy   = $signed({r_rdy[31], r_rdy}) - $signed({r_y0[31], r_y0});
    assign w_m    = (r_ax > r_ay) ? r_ax : r_ay;
    assign w_sq_t = r_res + r_bit;
    assign w_numx = 62'({r_ax[30:0], 30'd0}) + 62'(r_res[31:1]);
    assign w_numy = 62'({r_ay[30:0], 30'd0}) + 62'(r_res[31:1]);
    assign w_tx   = {r_remx, r_nqx[31]};
    assign w_ty   = {r_remy, r_nqy[31]};
    assign w_gex  = (w_tx >= {1'b0, r_len});
    assign w_gey  = (w_ty >= {1'b0, r_len});
    assign w_cx   = (r_nqx > 32'h4000_0000) ? 32'h4000_0000 : r_nqx;
    assign w_cy   = (r_nqy > 32'h4000_0000) ? 32'h4000_0000 : r_nqy;
    assign w_sumx = r_acc + 64'sd536870912;
    assign w_sumy = r_accy + 64'sd536870912;
    assign w_qx   = w_sumx[63:30];
    assign w_qy   = w_sumy[63:30];

    always_comb begin
        if (r_rx[34:31] == 4'b0000 || r_rx[34:31] == 4'b1111) begin
            w_satx = r_rx[31:0];
        end else begin
            w_satx = r_rx[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        if (r_ry[34:31] == 4'b0000 || r_ry[34:31] == 4'b1111) begin
            w_saty = r_ry[31:0];
        end else begin
            w_saty = r_ry[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_k         <= '0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_it    <= i_item;
                        r_n     <= i_count;
                        r_state <= i_item.is_load ? S_LOAD : S_RD0;
                    end
                end
                S_LOAD: begin
                    r_state <= S_FIN;
                end
                S_RD0: begin
                    r_state <= S_CMP0;
                end
                S_CMP0: begin
                    r_prev  <= '0;
                    r_clamp <= (r_it.qs <= r_rds);
                    r_state <= (r_it.qs <= r_rds) ? S_RDP : S_SRCH;
                end
                S_SRCH: begin
                    r_state <= (w_prev1 < r_n) ? S_SCMP : S_RDP;
                end
                S_SCMP: begin
                    if (r_it.qs > r_rds) begin
                        r_prev  <= r_prev + AW'(1);
                        r_state <= S_SRCH;
                    end else begin
                        r_state <= S_RDP;
                    end
                end
                S_RDP: begin
                    r_state <= S_RDN;
                end
                S_RDN: begin
                    r_x0    <= r_rdx;
                    r_y0    <= r_rdy;
                    r_seg   <= 32'({1'b0, r_it.qs}) - 32'({1'b0, r_rds});
                    r_state <= S_GOTN;
                end
                S_GOTN: begin
                    r_sx   <= w_dx[32];
                    r_sy   <= w_dy[32];
                    r_ax   <= w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
                    r_ay   <= w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
                    r_step <= '0;
                    if (w_dx == '0 && w_dy == '0) begin
                        // Coincident endpoints: direction along +x.
                        r_ux    <= 32'sh4000_0000;
                        r_uy    <= '0;
                        r_state <= S_PROD;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (w_m[32:31] != 2'b00) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (!w_m[30]) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= w_mult;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd1) begin
                        r_acc <= r_prod[63:0];
                    end else if (r_step == 3'd2) begin
                        r_v     <= r_acc + r_prod[63:0];
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_v >= w_sq_t) begin
                        r_v   <= r_v - w_sq_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    // The high part of each numerator is already below the length.
                    r_len   <= r_res[31:0];
                    r_remx  <= 32'(w_numx[61:32]);
                    r_remy  <= 32'(w_numy[61:32]);
                    r_nqx   <= w_numx[31:0];
                    r_nqy   <= w_numy[31:0];
                    r_k     <= 5'd31;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_remx <= w_gex ? 32'(w_tx - {1'b0, r_len}) : w_tx[31:0];
                    r_remy <= w_gey ? 32'(w_ty - {1'b0, r_len}) : w_ty[31:0];
                    r_nqx  <= {r_nqx[30:0], w_gex};
                    r_nqy  <= {r_nqy[30:0], w_gey};
                    r_k    <= r_k - 5'd1;
                    if (r_k == 5'd0) begin
                        r_state <= S_UNIT;
                    end
                end
                S_UNIT: begin
                    r_ux    <= r_sx ? -$signed(w_cx) : $signed(w_cx);
                    r_uy    <= r_sy ? -$signed(w_cy) : $signed(w_cy);
                    r_step  <= '0;
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_prod <= w_mult;
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_acc  <= r_prod[63:0];
                        3'd2: r_acc  <= r_acc + $signed(r_prod[63:0]);
                        3'd3: r_accy <= r_prod[63:0];
                        3'd4: begin
                            r_accy  <= r_accy - $signed(r_prod[63:0]);
                            r_state <= S_RND;
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
                S_RND: begin
                    r_rx    <= {w_qx[33], w_qx} + {{3{r_x0[31]}}, r_x0};
                    r_ry    <= {w_qy[33], w_qy} + {{3{r_y0[31]}}, r_y0};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        if (r_it.is_load) begin
                            r_out_x      <= '0;
                            r_out_y      <= '0;
                            r_out_seg    <= '0;
                            r_out_status <= ST_LOADED;
                        end else begin
                            r_out_x      <= w_satx;
                            r_out_y      <= w_saty;
                            r_out_seg    <= w_prev_ext[7:0];
                            r_out_status <= r_clamp ? ST_CLAMPED : ST_CONVERTED;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_segment_start = r_out_seg;
    assign o_status        = r_out_status;

endmodule

// ===== design/frenet_to_cartesian_top.sv =====
// Top level of the Frenet-to-Cartesian waypoint converter.
// A load result is written to the tables in S_LOAD when its index is in range and is
// then registered out in S_FIN. A convert runs the linear table search up to the chosen
// segment start, the normalize shifter, the 32-step square root, the 32-step divider,
// the products and the rounding. One item is in the back end at a time.
// Reset (synchronous, active low) empties the queue, sets waypoint_count to 256 and
// leaves the tables as they are.
module frenet_to_cartesian_top #(
    parameter int MAX_WAYPOINTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_wp_index,
    input  logic signed [31:0] i_wp_x,
    input  logic signed [31:0] i_wp_y,
    input  logic [30:0]        i_wp_s,
    input  logic [30:0]        i_query_s,
    input  logic signed [31:0] i_query_d,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic [7:0]         o_segment_start,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data
);
    import fc_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

    logic [8:0]    r_wp_count;
    logic [CW-1:0] w_cnt_ext;
    logic [CW-1:0] w_n;
    t_item         w_item;
    logic          w_item_valid;
    logic          w_item_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp_count <= 9'd256;
        end else if (i_cfg_we) begin
            r_wp_count <= i_cfg_data;
        end
    end

    assign w_cnt_ext = CW'(r_wp_count);
    assign w_n = (w_cnt_ext < CW'(2)) ? CW'(2) :
                 (w_cnt_ext > CW'(MAX_WAYPOINTS)) ? CW'(MAX_WAYPOINTS) : w_cnt_ext;

    fc_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_wp_index   (i_wp_index),
        .i_wp_x       (i_wp_x),
        .i_wp_y       (i_wp_y),
        .i_wp_s       (i_wp_s),
        .i_query_s    (i_query_s),
        .i_query_d    (i_query_d),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    fc_back #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_item),
        .i_item_valid    (w_item_valid),
        .o_item_pop      (w_item_pop),
        .i_count         (w_n),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_segment_start (o_segment_start),
        .o_status        (o_status)
    );

    // The front end only stalls transfers while it holds queued items.
    a_stall_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_item_valid)
        else $error("input stalled with an empty queue");

    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_LOADED) |->
        (o_out_x == '0 && o_out_y == '0 && o_segment_start == '0))
        else $error("load result carries nonzero fields");

    a_clamp_seg0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_CLAMPED) |-> (o_segment_start == '0))
        else $error("clamped query not on first segment");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_CLAMPED))
        else $error("unused status code on output");

endmodule
